// File: hdl/hcmb_pkg.sv
package hcmb_pkg;

  // store geometry
  localparam int STORE_AW    = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  // field widths
  localparam int HGT_W      = 16;
  localparam int EXT_W      = 24;
  localparam int TEX_W      = 17;
  localparam int NRM_W      = 16;
  localparam int IDX_W      = 11;
  localparam int POS_W      = 8;
  localparam int GRIDCFG_W  = 9;
  localparam int CHUNKCFG_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // normal search arithmetic
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 34;
  localparam int LO_W       = 15;
  localparam int FRAC_SHIFT = 28;

  localparam logic signed [NRM_W-1:0] NRM_ONE = 16'sd16384;

  // register reset values
  localparam logic [GRIDCFG_W-1:0] GRID_RESET = 9'd256;
  localparam logic [EXT_W-1:0]     EXT_RESET  = 24'd65536;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_VERTEX = 2'd1,
    CMD_QUAD   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_EXTENT      = 3'd2,
    CFG_CHUNK_COL   = 3'd3,
    CFG_CHUNK_ROW   = 3'd4
  } cfg_idx_t;

  // request from the sequencer to the normal unit
  typedef struct packed {
    logic go;
    logic neg_x;
    logic neg_z;
  } nrm_req_t;

endpackage

// File: hdl/hcmb_ifs.sv
interface hcmb_in_if;
  import hcmb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [POS_W-1:0]        pos_x;
  logic [POS_W-1:0]        pos_y;
  logic signed [HGT_W-1:0] sample_height;

  modport source (output valid, command, pos_x, pos_y, sample_height, input ready);
  modport sink   (input valid, command, pos_x, pos_y, sample_height, output ready);
endinterface

interface hcmb_out_if;
  import hcmb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [EXT_W-1:0]        world_x;
  logic [EXT_W-1:0]        world_z;
  logic signed [HGT_W-1:0] vertex_height;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic [IDX_W-1:0]        vertex_index;
  logic                    status;
  logic                    last;

  modport source (output valid, world_x, world_z, vertex_height, tex_u, tex_v,
                  normal_x, normal_y, normal_z, vertex_index, status, last,
                  input ready);
  modport sink   (input valid, world_x, world_z, vertex_height, tex_u, tex_v,
                  normal_x, normal_y, normal_z, vertex_index, status, last,
                  output ready);
endinterface

// File: hdl/hcmb_store.sv
module hcmb_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [hcmb_pkg::STORE_AW-1:0]  wr_addr,
  input  logic [hcmb_pkg::HGT_W-1:0]     wr_data,
  input  logic [hcmb_pkg::STORE_AW-1:0]  rd_addr,
  output logic [hcmb_pkg::HGT_W-1:0]     rd_data,
  output logic                           busy
);
  import hcmb_pkg::*;

  logic [HGT_W-1:0]    mem [STORE_DEPTH];
  logic                clearing_r;
  logic [STORE_AW-1:0] clr_addr_r;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (rst_n && clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (rst_n && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = clearing_r;

endmodule

// File: hdl/hcmb_div.sv
module hcmb_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quot_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             ge;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem_r, quot_r[NUM_W-1]};
    rem_dif = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= num;
      den_r  <= den;
    end else if (busy_r) begin
      rem_r  <= ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot_r <= {quot_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: hdl/hcmb_norm.sv
module hcmb_norm #(
  parameter int MAG_W = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hcmb_pkg::nrm_req_t             req,
  input  logic [MAG_W-1:0]               mag_x,
  input  logic [MAG_W-1:0]               mag_y,
  input  logic [MAG_W-1:0]               mag_z,
  output logic                           done,
  output logic signed [hcmb_pkg::NRM_W-1:0] nx,
  output logic signed [hcmb_pkg::NRM_W-1:0] ny,
  output logic signed [hcmb_pkg::NRM_W-1:0] nz
);
  import hcmb_pkg::*;

  localparam int P_W   = 66;
  localparam int Q_W   = 50;
  localparam int BIT_W = 4;
  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(LO_W - 1);
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef enum logic [4:0] {
    N_IDLE  = 5'b00001,
    N_SHIFT = 5'b00010,
    N_SQ    = 5'b00100,
    N_TRY   = 5'b01000,
    N_CMP   = 5'b10000
  } nst_t;

  nst_t              st_r;
  logic              done_r;
  logic [MAG_W-1:0]  m_r [3];
  logic [SQ_W-1:0]   sq_r [3];
  logic              neg_x_r;
  logic              neg_z_r;
  logic [1:0]        comp_r;
  logic [SUM_W-1:0]  s_r;
  logic [LO_W-1:0]   lo_r;
  logic [P_W-1:0]    p_r;
  logic [P_W-1:0]    pt_r;
  logic [Q_W-1:0]    q_r;
  logic [Q_W-1:0]    qt_r;
  logic [BIT_W-1:0]  bit_r;
  logic signed [NRM_W-1:0] nx_r;
  logic signed [NRM_W-1:0] ny_r;
  logic signed [NRM_W-1:0] nz_r;

  logic              too_big;
  logic [15:0]       m_sel;
  logic [SQ_W-1:0]   sq_val;
  logic [P_W-1:0]    pt_val;
  logic [Q_W-1:0]    qt_val;
  logic [P_W-1:0]    target;
  logic              fit;
  logic [LO_W-1:0]   lo_fin;
  logic              neg_sel;
  logic signed [NRM_W-1:0] res;

  always_comb begin
    // all three magnitudes shift together until they fit in 16 bits
    too_big = ((m_r[0] >> 16) != '0) || ((m_r[1] >> 16) != '0) ||
              ((m_r[2] >> 16) != '0);
    m_sel   = m_r[comp_r][15:0];
    sq_val  = SQ_W'(m_sel) * SQ_W'(m_sel);
    // trial (lo + 2^b)^2 * s built from lo*s and lo^2*s
    pt_val  = p_r + (P_W'(q_r) << ({1'b0, bit_r} + 5'd1)) +
              (P_W'(s_r) << {bit_r, 1'b0});
    qt_val  = q_r + (Q_W'(s_r) << bit_r);
    target  = P_W'(sq_r[comp_r]) << FRAC_SHIFT;
    fit     = (pt_r <= target);
    lo_fin  = fit ? (lo_r | (LO_W'(1) << bit_r)) : lo_r;
    case (comp_r)
      COMP_X:  neg_sel = neg_x_r;
      COMP_Z:  neg_sel = neg_z_r;
      default: neg_sel = 1'b0;
    endcase
    res = neg_sel ? -$signed(NRM_W'(lo_fin)) : $signed(NRM_W'(lo_fin));
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        N_IDLE: begin
          if (req.go) begin
            m_r[0]  <= mag_x;
            m_r[1]  <= mag_y;
            m_r[2]  <= mag_z;
            neg_x_r <= req.neg_x;
            neg_z_r <= req.neg_z;
            st_r    <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (too_big) begin
            m_r[0] <= m_r[0] >> 1;
            m_r[1] <= m_r[1] >> 1;
            m_r[2] <= m_r[2] >> 1;
          end else begin
            comp_r <= COMP_X;
            s_r    <= '0;
            st_r   <= N_SQ;
          end
        end
        N_SQ: begin
          sq_r[comp_r] <= sq_val;
          s_r          <= s_r + SUM_W'(sq_val);
          if (comp_r == COMP_Z) begin
            comp_r <= COMP_X;
            lo_r   <= '0;
            p_r    <= '0;
            q_r    <= '0;
            bit_r  <= TOP_BIT;
            st_r   <= N_TRY;
          end else begin
            comp_r <= comp_r + 1'b1;
          end
        end
        N_TRY: begin
          pt_r <= pt_val;
          qt_r <= qt_val;
          st_r <= N_CMP;
        end
        N_CMP: begin
          if (fit) begin
            p_r <= pt_r;
            q_r <= qt_r;
          end
          lo_r <= lo_fin;
          st_r <= N_TRY;
          if (bit_r == '0) begin
            case (comp_r)
              COMP_X:  nx_r <= res;
              COMP_Y:  ny_r <= res;
              default: nz_r <= res;
            endcase
            lo_r  <= '0;
            p_r   <= '0;
            q_r   <= '0;
            bit_r <= TOP_BIT;
            if (comp_r == COMP_Z) begin
              done_r <= 1'b1;
              st_r   <= N_IDLE;
            end else begin
              comp_r <= comp_r + 1'b1;
            end
          end else begin
            bit_r <= bit_r - 1'b1;
          end
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign nx   = nx_r;
  assign ny   = ny_r;
  assign nz   = nz_r;

endmodule

// File: hdl/heightmap_chunk_mesh_builder_unit.sv
// Terrain chunk mesh builder. A 64K x 16 height store is loaded by write
// requests (ignored outside the grid); a vertex request returns one result
// with world X/Z, height, texture U/V and a Q1.14 unit normal, a quad
// request returns six triangle indices with the last one marked, and a
// point outside the chunk returns one result with status 1. Items are
// handled one at a time. After reset the store is swept to zero, during
// which no request is taken; configuration writes are taken at any time.
// A vertex goes through an address check, five store reads, a gradient
// step, four divisions on one shared restoring divider of
// (clog2(MAX_GRID_SIDE+1)+25) steps each, and for interior points the
// normal unit: a load, a shift of all three magnitudes by up to 9 bits,
// three squarings, 3 x 15 search steps of a trial and a compare each, and
// a hand-off. A quad passes an address check before its six results.
module heightmap_chunk_mesh_builder_unit #(
  parameter int CHUNK_CELLS   = 32,
  parameter int MAX_GRID_SIDE = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hcmb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hcmb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  hcmb_in_if.sink                           in_req,
  hcmb_out_if.source                        out_res
);
  import hcmb_pkg::*;

  localparam int SIDE_W = $clog2(MAX_GRID_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > GRIDCFG_W) ? SIDE_W : GRIDCFG_W;
  localparam int ORG_W  = CHUNKCFG_W + $clog2(CHUNK_CELLS + 1);
  localparam int VW     = (ORG_W + 2 > CMP_W) ? ORG_W + 2 : CMP_W;
  localparam int CW_W   = $clog2(CHUNK_CELLS + 2);
  localparam int NUM_W  = SIDE_W + EXT_W + 1;
  localparam int MAG_W  = (HGT_W + SIDE_W > EXT_W + 1) ? HGT_W + SIDE_W : EXT_W + 1;
  localparam int AP_W   = POS_W + SIDE_W + 1;
  localparam int BP_W   = 2 * SIDE_W + 1;
  localparam int IP_W   = POS_W + CW_W + 1;

  // neighbor read slots
  localparam logic [2:0] RD_C    = 3'd0;
  localparam logic [2:0] RD_L    = 3'd1;
  localparam logic [2:0] RD_R    = 3'd2;
  localparam logic [2:0] RD_D    = 3'd3;
  localparam logic [2:0] RD_U    = 3'd4;
  localparam logic [2:0] RD_DONE = 3'd5;

  // division slots
  localparam logic [1:0] DV_WX = 2'd0;
  localparam logic [1:0] DV_WZ = 2'd1;
  localparam logic [1:0] DV_TU = 2'd2;
  localparam logic [1:0] DV_TV = 2'd3;

  localparam logic [2:0] QUAD_LAST = 3'd5;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_READ  = 9'b000000100,
    S_GRAD  = 9'b000001000,
    S_DPREP = 9'b000010000,
    S_DRUN  = 9'b000100000,
    S_NORM  = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_QUAD  = 9'b100000000
  } st_t;

  // configuration registers
  logic [GRIDCFG_W-1:0]  grid_width_r;
  logic [GRIDCFG_W-1:0]  grid_height_r;
  logic [EXT_W-1:0]      extent_r;
  logic [CHUNKCFG_W-1:0] column_r;
  logic [CHUNKCFG_W-1:0] row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_RESET;
      grid_height_r <= GRID_RESET;
      extent_r      <= EXT_RESET;
      column_r      <= '0;
      row_r         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[GRIDCFG_W-1:0];
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata[GRIDCFG_W-1:0];
        CFG_EXTENT:      extent_r      <= cfg_wdata[EXT_W-1:0];
        CFG_CHUNK_COL:   column_r      <= cfg_wdata[CHUNKCFG_W-1:0];
        CFG_CHUNK_ROW:   row_r         <= cfg_wdata[CHUNKCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective grid size, extent and chunk origin
  logic [CMP_W-1:0]  gw_c, gh_c;
  logic [SIDE_W-1:0] w_eff, h_eff, wm1, hm1;
  logic [EXT_W-1:0]  ext_eff;
  logic [ORG_W-1:0]  sx, sy;

  always_comb begin
    gw_c  = CMP_W'(grid_width_r);
    gh_c  = CMP_W'(grid_height_r);
    w_eff = (gw_c < CMP_W'(2)) ? SIDE_W'(2) :
            (gw_c > CMP_W'(MAX_GRID_SIDE)) ? SIDE_W'(MAX_GRID_SIDE) : SIDE_W'(gw_c);
    h_eff = (gh_c < CMP_W'(2)) ? SIDE_W'(2) :
            (gh_c > CMP_W'(MAX_GRID_SIDE)) ? SIDE_W'(MAX_GRID_SIDE) : SIDE_W'(gh_c);
    wm1     = w_eff - 1'b1;
    hm1     = h_eff - 1'b1;
    ext_eff = (extent_r == '0) ? EXT_W'(1) : extent_r;
    sx      = ORG_W'(column_r) * ORG_W'(CHUNK_CELLS);
    sy      = ORG_W'(row_r) * ORG_W'(CHUNK_CELLS);
  end

  st_t                 state_r;
  logic [1:0]          cmd_r;
  logic [POS_W-1:0]    px_r, py_r;
  logic [SIDE_W-1:0]   x_r, y_r;
  logic [STORE_AW-1:0] base_r;
  logic [2:0]          rd_k_r;
  logic [HGT_W-1:0]    hv_r [5];
  logic [1:0]          div_k_r;
  logic                div_go_r;
  logic                nrm_go_r;
  logic                interior_r;
  logic [NUM_W-1:0]    num_r;
  logic [SIDE_W-1:0]   den_r;
  logic [MAG_W-1:0]    mag_x_r, mag_y_r, mag_z_r;
  logic                neg_x_r, neg_z_r;
  logic [IDX_W-1:0]    i0_r;
  logic [CW_W-1:0]     cw_r;
  logic [2:0]          qk_r;

  // result payload registers
  logic [EXT_W-1:0]        world_x_r, world_z_r;
  logic [HGT_W-1:0]        height_r;
  logic [TEX_W-1:0]        tex_u_r, tex_v_r;
  logic signed [NRM_W-1:0] nx_r, ny_r, nz_r;
  logic                    stat_r;

  logic                in_fire;
  logic                out_fire;
  logic                store_busy;
  logic                wr_ok;
  logic [STORE_AW-1:0] wr_addr;
  logic [STORE_AW-1:0] rd_addr;
  logic [HGT_W-1:0]    rd_data;
  logic [VW-1:0]       x_full, y_full, cw_full;
  logic                ok_vx, ok_vy, ok_qx, ok_qy;
  logic [CW_W-1:0]     cw_val;
  logic signed [HGT_W:0] dx, dz;
  logic [HGT_W-1:0]    adx, adz;
  logic [IDX_W-1:0]    i1, i2, i3, idx_seq;
  logic                div_done, nrm_done;
  logic [NUM_W-1:0]    div_quot;
  nrm_req_t            nrm_req;
  logic signed [NRM_W-1:0] nrm_x, nrm_y, nrm_z;

  assign in_fire  = in_req.valid && in_req.ready;
  assign out_fire = out_res.valid && out_res.ready;

  // sample write straight from the request
  always_comb begin
    wr_ok = in_fire && (in_req.command == CMD_WRITE) &&
            (VW'(in_req.pos_x) < VW'(w_eff)) && (VW'(in_req.pos_y) < VW'(h_eff));
    wr_addr = STORE_AW'(AP_W'(in_req.pos_y) * AP_W'(w_eff) + AP_W'(in_req.pos_x));
  end

  // chunk extent checks and chunk row width for the quad base index
  always_comb begin
    x_full  = VW'(sx) + VW'(px_r);
    y_full  = VW'(sy) + VW'(py_r);
    ok_vx   = (VW'(px_r) <= VW'(CHUNK_CELLS)) && (x_full < VW'(w_eff));
    ok_vy   = (VW'(py_r) <= VW'(CHUNK_CELLS)) && (y_full < VW'(h_eff));
    ok_qx   = (VW'(px_r) < VW'(CHUNK_CELLS)) && ((x_full + 1'b1) < VW'(w_eff));
    ok_qy   = (VW'(py_r) < VW'(CHUNK_CELLS)) && ((y_full + 1'b1) < VW'(h_eff));
    cw_full = VW'(w_eff) - VW'(sx);
    cw_val  = (cw_full < VW'(CHUNK_CELLS + 1)) ? CW_W'(cw_full) : CW_W'(CHUNK_CELLS + 1);
  end

  // neighbor address and height differences
  always_comb begin
    case (rd_k_r)
      RD_C:    rd_addr = base_r;
      RD_L:    rd_addr = base_r - 1'b1;
      RD_R:    rd_addr = base_r + 1'b1;
      RD_D:    rd_addr = base_r - STORE_AW'(w_eff);
      RD_U:    rd_addr = base_r + STORE_AW'(w_eff);
      default: rd_addr = base_r;
    endcase
    dx  = $signed({hv_r[RD_L][HGT_W-1], hv_r[RD_L]}) -
          $signed({hv_r[RD_R][HGT_W-1], hv_r[RD_R]});
    dz  = $signed({hv_r[RD_D][HGT_W-1], hv_r[RD_D]}) -
          $signed({hv_r[RD_U][HGT_W-1], hv_r[RD_U]});
    adx = dx[HGT_W] ? HGT_W'(-dx) : HGT_W'(dx);
    adz = dz[HGT_W] ? HGT_W'(-dz) : HGT_W'(dz);
  end

  // triangle index order i0,i2,i1, i1,i2,i3
  always_comb begin
    i1 = i0_r + 1'b1;
    i2 = i0_r + IDX_W'(cw_r);
    i3 = i2 + 1'b1;
    case (qk_r)
      3'd0:    idx_seq = i0_r;
      3'd1:    idx_seq = i2;
      3'd2:    idx_seq = i1;
      3'd3:    idx_seq = i1;
      3'd4:    idx_seq = i2;
      default: idx_seq = i3;
    endcase
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      div_go_r <= 1'b0;
      nrm_go_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      nrm_go_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r <= in_req.command;
            px_r  <= in_req.pos_x;
            py_r  <= in_req.pos_y;
            if ((in_req.command == CMD_VERTEX) || (in_req.command == CMD_QUAD)) begin
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          world_x_r <= '0;
          world_z_r <= '0;
          height_r  <= '0;
          tex_u_r   <= '0;
          tex_v_r   <= '0;
          nx_r      <= '0;
          ny_r      <= '0;
          nz_r      <= '0;
          stat_r    <= 1'b0;
          x_r       <= SIDE_W'(x_full);
          y_r       <= SIDE_W'(y_full);
          base_r    <= STORE_AW'(BP_W'(SIDE_W'(y_full)) * BP_W'(w_eff) +
                                 BP_W'(SIDE_W'(x_full)));
          rd_k_r    <= RD_C;
          cw_r      <= cw_val;
          i0_r      <= IDX_W'(IP_W'(py_r) * IP_W'(cw_val) + IP_W'(px_r));
          qk_r      <= '0;
          if ((cmd_r == CMD_VERTEX) && ok_vx && ok_vy) begin
            state_r <= S_READ;
          end else if ((cmd_r == CMD_QUAD) && ok_qx && ok_qy) begin
            state_r <= S_QUAD;
          end else begin
            stat_r  <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_READ: begin
          if (rd_k_r != RD_C) begin
            hv_r[rd_k_r - 1'b1] <= rd_data;
          end
          rd_k_r <= rd_k_r + 1'b1;
          if (rd_k_r == RD_DONE) begin
            state_r <= S_GRAD;
          end
        end
        S_GRAD: begin
          height_r   <= hv_r[RD_C];
          interior_r <= (x_r != '0) && (x_r < wm1) && (y_r != '0) && (y_r < hm1);
          mag_x_r    <= MAG_W'(adx) * MAG_W'(wm1);
          mag_z_r    <= MAG_W'(adz) * MAG_W'(hm1);
          mag_y_r    <= MAG_W'({ext_eff, 1'b0});
          neg_x_r    <= dx[HGT_W];
          neg_z_r    <= dz[HGT_W];
          nx_r       <= '0;
          ny_r       <= NRM_ONE;
          nz_r       <= '0;
          div_k_r    <= DV_WX;
          state_r    <= S_DPREP;
        end
        S_DPREP: begin
          case (div_k_r)
            DV_WX: begin
              num_r <= NUM_W'(x_r) * NUM_W'(ext_eff) + NUM_W'(wm1 >> 1);
              den_r <= wm1;
            end
            DV_WZ: begin
              num_r <= NUM_W'(y_r) * NUM_W'(ext_eff) + NUM_W'(hm1 >> 1);
              den_r <= hm1;
            end
            DV_TU: begin
              num_r <= (NUM_W'(x_r) << 16) + NUM_W'(wm1 >> 1);
              den_r <= wm1;
            end
            default: begin
              num_r <= (NUM_W'(y_r) << 16) + NUM_W'(hm1 >> 1);
              den_r <= hm1;
            end
          endcase
          div_go_r <= 1'b1;
          state_r  <= S_DRUN;
        end
        S_DRUN: begin
          if (div_done) begin
            case (div_k_r)
              DV_WX:   world_x_r <= div_quot[EXT_W-1:0];
              DV_WZ:   world_z_r <= div_quot[EXT_W-1:0];
              DV_TU:   tex_u_r   <= div_quot[TEX_W-1:0];
              default: tex_v_r   <= div_quot[TEX_W-1:0];
            endcase
            if (div_k_r == DV_TV) begin
              if (interior_r) begin
                nrm_go_r <= 1'b1;
                state_r  <= S_NORM;
              end else begin
                state_r <= S_OUT;
              end
            end else begin
              div_k_r <= div_k_r + 1'b1;
              state_r <= S_DPREP;
            end
          end
        end
        S_NORM: begin
          if (nrm_done) begin
            nx_r    <= nrm_x;
            ny_r    <= nrm_y;
            nz_r    <= nrm_z;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            state_r <= S_IDLE;
          end
        end
        S_QUAD: begin
          if (out_fire) begin
            if (qk_r == QUAD_LAST) begin
              state_r <= S_IDLE;
            end else begin
              qk_r <= qk_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // height store
  hcmb_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_ok),
    .wr_addr (wr_addr),
    .wr_data (in_req.sample_height),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (store_busy)
  );

  // shared divider for world and texture coordinates
  hcmb_div #(
    .NUM_W (NUM_W),
    .DEN_W (SIDE_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // normal unit
  always_comb begin
    nrm_req.go    = nrm_go_r;
    nrm_req.neg_x = neg_x_r;
    nrm_req.neg_z = neg_z_r;
  end

  hcmb_norm #(
    .MAG_W (MAG_W)
  ) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nrm_req),
    .mag_x (mag_x_r),
    .mag_y (mag_y_r),
    .mag_z (mag_z_r),
    .done  (nrm_done),
    .nx    (nrm_x),
    .ny    (nrm_y),
    .nz    (nrm_z)
  );

  // channel ports
  assign in_req.ready          = (state_r == S_IDLE) && !store_busy;
  assign out_res.valid         = (state_r == S_OUT) || (state_r == S_QUAD);
  assign out_res.world_x       = world_x_r;
  assign out_res.world_z       = world_z_r;
  assign out_res.vertex_height = height_r;
  assign out_res.tex_u         = tex_u_r;
  assign out_res.tex_v         = tex_v_r;
  assign out_res.normal_x      = nx_r;
  assign out_res.normal_y      = ny_r;
  assign out_res.normal_z      = nz_r;
  assign out_res.vertex_index  = (state_r == S_QUAD) ? idx_seq : '0;
  assign out_res.status        = stat_r;
  assign out_res.last          = (state_r == S_OUT) ||
                                 ((state_r == S_QUAD) && (qk_r == QUAD_LAST));

endmodule

// File: dv/heightmap_chunk_mesh_builder_unit_tb.sv
module heightmap_chunk_mesh_builder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hcmb_pkg::*;

  localparam int CHUNK = 32;
  localparam int MAX_SIDE = 256;
  localparam int DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [EXT_W-1:0] world_x;
    logic [EXT_W-1:0] world_z;
    logic [HGT_W-1:0] vertex_height;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [NRM_W-1:0] normal_x;
    logic [NRM_W-1:0] normal_y;
    logic [NRM_W-1:0] normal_z;
    logic [IDX_W-1:0] vertex_index;
    logic             status;
    logic             last;
  } mesh_res_t;

  // mesh predictor and expected-result store
  class mesh_scoreboard;
    logic [HGT_W-1:0] hstore [STORE_DEPTH];
    logic [GRIDCFG_W-1:0] grid_w, grid_h;
    logic [EXT_W-1:0] extent;
    logic [CHUNKCFG_W-1:0] chunk_col, chunk_row;
    mesh_res_t pending[$];
    int errors;

    function new();
      foreach (hstore[i]) hstore[i] = '0;
      grid_w = GRID_RESET;
      grid_h = GRID_RESET;
      extent = EXT_RESET;
      chunk_col = '0;
      chunk_row = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_GRID_WIDTH:  grid_w = val[GRIDCFG_W-1:0];
        CFG_GRID_HEIGHT: grid_h = val[GRIDCFG_W-1:0];
        CFG_EXTENT:      extent = val;
        CFG_CHUNK_COL:   chunk_col = val[CHUNKCFG_W-1:0];
        CFG_CHUNK_ROW:   chunk_row = val[CHUNKCFG_W-1:0];
        default: ;
      endcase
    endfunction

    // queue one expected result at the tail
    function void add_expected(mesh_res_t r);
      pending.insert(pending.size(), r);
    endfunction

    function int side(logic [GRIDCFG_W-1:0] v);
      if (v < 2) return 2;
      if (v > MAX_SIDE) return MAX_SIDE;
      return int'(v);
    endfunction

    function longint sample_at(int x, int y, int w);
      logic signed [HGT_W-1:0] s;
      s = hstore[(y * w + x) & (STORE_DEPTH - 1)];
      return longint'(s);
    endfunction

    function longint unsigned rounded_div(longint unsigned num, longint unsigned den);
      return (num + den / 2) / den;
    endfunction

    // largest q with q*q*s <= m*m*2^28
    function longint unsigned unit_part(longint unsigned m, longint unsigned s);
      longint unsigned target, lo, hi, mid;
      target = (m * m) << FRAC_SHIFT;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * s <= target) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function logic [NRM_W-1:0] apply_sign(longint unsigned mag, bit neg);
      return neg ? NRM_W'(-mag) : NRM_W'(mag);
    endfunction

    function void note_request(cmd_t cmd, int px, int py, logic [HGT_W-1:0] hgt);
      int w, h, sx, sy, ex, ey, cw, chh, x, y;
      longint unsigned ext, ma, mc, md, s;
      longint a, c;
      int idx [6];
      mesh_res_t r;
      w = side(grid_w);
      h = side(grid_h);
      ext = (extent == 0) ? 1 : longint'(extent);
      sx = chunk_col * CHUNK;
      sy = chunk_row * CHUNK;
      ex = sx + CHUNK + 1;
      ey = sy + CHUNK + 1;
      if (cmd == CMD_WRITE) begin
        if (px < w && py < h) hstore[(py * w + px) & (STORE_DEPTH - 1)] = hgt;
        return;
      end
      if (cmd == CMD_NONE) return;
      if (ex > w) ex = w;
      if (ey > h) ey = h;
      cw = ex > sx ? ex - sx : 0;
      chh = ey > sy ? ey - sy : 0;
      r = '{default: '0};
      if (cmd == CMD_VERTEX) begin
        if (px >= cw || py >= chh) begin
          r.status = 1'b1;
          r.last = 1'b1;
          add_expected(r);
          return;
        end
        x = sx + px;
        y = sy + py;
        r.world_x = EXT_W'(rounded_div(longint'(x) * ext, w - 1));
        r.world_z = EXT_W'(rounded_div(longint'(y) * ext, h - 1));
        r.vertex_height = HGT_W'(sample_at(x, y, w));
        r.tex_u = TEX_W'(rounded_div(longint'(x) << 16, w - 1));
        r.tex_v = TEX_W'(rounded_div(longint'(y) << 16, h - 1));
        if (x > 0 && x < w - 1 && y > 0 && y < h - 1) begin
          // central differences, scaled down until all fit 16 bits
          a = (sample_at(x - 1, y, w) - sample_at(x + 1, y, w)) * (w - 1);
          c = (sample_at(x, y - 1, w) - sample_at(x, y + 1, w)) * (h - 1);
          ma = a < 0 ? -a : a;
          mc = c < 0 ? -c : c;
          md = 2 * ext;
          while (ma >= 65536 || mc >= 65536 || md >= 65536) begin
            ma >>= 1;
            mc >>= 1;
            md >>= 1;
          end
          s = ma * ma + mc * mc + md * md;
          r.normal_x = apply_sign(unit_part(ma, s), a < 0);
          r.normal_y = apply_sign(unit_part(md, s), 1'b0);
          r.normal_z = apply_sign(unit_part(mc, s), c < 0);
        end else begin
          r.normal_y = NRM_ONE;
        end
        r.last = 1'b1;
        add_expected(r);
        return;
      end
      // quad: two triangles i0,i2,i1 and i1,i2,i3
      if (px + 1 >= cw || py + 1 >= chh) begin
        r.status = 1'b1;
        r.last = 1'b1;
        add_expected(r);
        return;
      end
      idx[0] = py * cw + px;
      idx[2] = idx[0] + 1;
      idx[1] = idx[0] + cw;
      idx[3] = idx[2];
      idx[4] = idx[1];
      idx[5] = idx[1] + 1;
      for (int k = 0; k < 6; k++) begin
        r = '{default: '0};
        r.vertex_index = IDX_W'(idx[k]);
        r.last = (k == 5);
        add_expected(r);
      end
    endfunction

    function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(mesh_res_t act);
      mesh_res_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual index %0h status %0b",
                 $time, act.vertex_index, act.status);
        return;
      end
      e = pending.pop_front();
      field_check("world_x", e.world_x, act.world_x);
      field_check("world_z", e.world_z, act.world_z);
      field_check("vertex_height", e.vertex_height, act.vertex_height);
      field_check("tex_u", e.tex_u, act.tex_u);
      field_check("tex_v", e.tex_v, act.tex_v);
      field_check("normal_x", e.normal_x, act.normal_x);
      field_check("normal_y", e.normal_y, act.normal_y);
      field_check("normal_z", e.normal_z, act.normal_z);
      field_check("vertex_index", e.vertex_index, act.vertex_index);
      field_check("status", e.status, act.status);
      field_check("last", e.last, act.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  hcmb_in_if in_req ();
  hcmb_out_if out_res ();

  mesh_scoreboard mesh_sb;
  longint cycle_count;
  bit steady;
  int out_stall;

  heightmap_chunk_mesh_builder_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_req(in_req),
    .out_res(out_res)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_res.ready <= 1'b0;
      out_stall--;
    end else begin
      out_res.ready <= 1'b1;
      out_stall = gap_len();
    end
  end

  // result monitor
  always @(posedge clk) begin
    mesh_res_t r;
    if (rst_n && out_res.valid && out_res.ready) begin
      r.world_x = out_res.world_x;
      r.world_z = out_res.world_z;
      r.vertex_height = out_res.vertex_height;
      r.tex_u = out_res.tex_u;
      r.tex_v = out_res.tex_v;
      r.normal_x = out_res.normal_x;
      r.normal_y = out_res.normal_y;
      r.normal_z = out_res.normal_z;
      r.vertex_index = out_res.vertex_index;
      r.status = out_res.status;
      r.last = out_res.last;
      mesh_sb.check_result(r);
    end
  end

  // one request; called and returning at a rising edge
  task automatic send_request(cmd_t cmd, int px, int py, logic [HGT_W-1:0] hgt);
    int g;
    in_req.valid <= 1'b1;
    in_req.command <= cmd;
    in_req.pos_x <= POS_W'(px);
    in_req.pos_y <= POS_W'(py);
    in_req.sample_height <= hgt;
    do @(posedge clk); while (!in_req.ready);
    mesh_sb.note_request(cmd, px & 8'hFF, py & 8'hFF, hgt);
    g = gap_len();
    if (g > 0) begin
      in_req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    while (mesh_sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write, then the write enable is dropped
  task automatic write_reg(cfg_idx_t idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    mesh_sb.set_reg(idx, CFG_DATA_W'(val));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_side();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1);
      1: return $urandom_range(257, 511);
      2: return $urandom_range(81, 256);
      default: return $urandom_range(2, 80);
    endcase
  endfunction

  function automatic int pick_extent();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 24'hFFFFFF;
      2: return $urandom_range(1, 255);
      default: return $urandom_range(256, 24'h40000);
    endcase
  endfunction

  function automatic int pick_chunk(int v);
    int s;
    s = v < 2 ? 2 : (v > MAX_SIDE ? MAX_SIDE : v);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, s / CHUNK + 1);
  endfunction

  task automatic random_phase(int n);
    int sx, sy, p;
    logic [HGT_W-1:0] hgt;
    sx = mesh_sb.chunk_col * CHUNK;
    sy = mesh_sb.chunk_row * CHUNK;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      hgt = $urandom_range(0, 3) == 0 ? HGT_W'($urandom_range(0, 64) - 32) : HGT_W'($urandom);
      if (p < 40) begin
        // samples mostly around the current chunk
        if ($urandom_range(0, 7) == 0)
          send_request(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 255), hgt);
        else
          send_request(CMD_WRITE, sx + $urandom_range(0, 34), sy + $urandom_range(0, 34), hgt);
      end else if (p < 70) begin
        if ($urandom_range(0, 7) == 0)
          send_request(CMD_VERTEX, $urandom_range(0, 255), $urandom_range(0, 255), hgt);
        else
          send_request(CMD_VERTEX, $urandom_range(0, 33), $urandom_range(0, 33), hgt);
      end else if (p < 95) begin
        if ($urandom_range(0, 7) == 0)
          send_request(CMD_QUAD, $urandom_range(0, 255), $urandom_range(0, 255), hgt);
        else
          send_request(CMD_QUAD, $urandom_range(0, 32), $urandom_range(0, 32), hgt);
      end else begin
        send_request(CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 255), hgt);
      end
    end
  endtask

  initial begin
    int gw, gh;
    mesh_sb = new();
    cycle_count = 0;
    steady = 1'b0;
    out_stall = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.command = CMD_NONE;
    in_req.pos_x = '0;
    in_req.pos_y = '0;
    in_req.sample_height = '0;
    out_res.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config, field extremes, border, interior and outside points, quads
    send_request(CMD_VERTEX, 1, 1, '0);
    send_request(CMD_WRITE, 0, 0, 16'sh7FFF);
    send_request(CMD_WRITE, 0, 1, 16'sh8000);
    send_request(CMD_WRITE, 2, 1, 16'sh7FFF);
    send_request(CMD_WRITE, 1, 2, 16'sh8000);
    send_request(CMD_WRITE, 255, 255, 16'shFFFF);
    send_request(CMD_VERTEX, 0, 0, '0);
    send_request(CMD_VERTEX, 1, 1, '0);
    send_request(CMD_VERTEX, 32, 32, '0);
    send_request(CMD_VERTEX, 33, 0, '0);
    send_request(CMD_VERTEX, 255, 255, '0);
    send_request(CMD_QUAD, 0, 0, '0);
    send_request(CMD_QUAD, 31, 31, '0);
    send_request(CMD_QUAD, 32, 0, '0);
    send_request(CMD_QUAD, 255, 255, '0);
    send_request(CMD_NONE, 170, 85, 16'h5555);
    drain();

    // directed: clamped grid, zero extent, far chunk
    write_reg(CFG_GRID_WIDTH, 0);
    write_reg(CFG_GRID_HEIGHT, 511);
    write_reg(CFG_EXTENT, 0);
    write_reg(CFG_CHUNK_COL, 255);
    write_reg(CFG_CHUNK_ROW, 255);
    send_request(CMD_WRITE, 5, 0, 16'h1234);
    send_request(CMD_VERTEX, 0, 0, '0);
    drain();
    write_reg(CFG_CHUNK_COL, 0);
    write_reg(CFG_CHUNK_ROW, 0);
    send_request(CMD_VERTEX, 1, 0, '0);
    send_request(CMD_QUAD, 0, 0, '0);
    drain();

    // random phases over random settings
    for (int ph = 0; ph < 8; ph++) begin
      steady = (ph == 3);
      gw = pick_side();
      gh = pick_side();
      write_reg(CFG_GRID_WIDTH, gw);
      write_reg(CFG_GRID_HEIGHT, gh);
      write_reg(CFG_EXTENT, ph == 7 ? 24'hFFFFFF : pick_extent());
      write_reg(CFG_CHUNK_COL, pick_chunk(gw));
      write_reg(CFG_CHUNK_ROW, pick_chunk(gh));
      random_phase(48);
      drain();
    end

    if (mesh_sb.errors == 0 && mesh_sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/hcmb_pkg.sv
hdl/hcmb_ifs.sv
hdl/hcmb_store.sv
hdl/hcmb_div.sv
hdl/hcmb_norm.sv
hdl/heightmap_chunk_mesh_builder_unit.sv
dv/heightmap_chunk_mesh_builder_unit_tb.sv
